// File: hw/rtl/dtck_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types of the document topic-count keeper
package dtck_pkg;

    // sizes of the stores
    localparam int MAX_TOPICS  = 64;
    localparam int TOPIC_W     = 6;
    localparam int MAX_TOKENS  = 1024;
    localparam int TOKEN_IDX_W = 10;
    localparam int TOKEN_CNT_W = 11;
    localparam int COUNT_W     = 11;
    localparam int COUNT_MAX   = 2047;
    localparam int ACCUM_BITS  = 32;
    localparam int SUM_W       = ACCUM_BITS + TOPIC_W;

    // item and result fields
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int FRAC_W   = 17;

    // one quotient bit per step, integer bit plus sixteen fraction bits
    localparam int DIV_STEPS  = 17;
    localparam int DIV_CNT_W  = 5;

    // configuration register
    localparam int CFG_W        = 7;
    localparam int TOPICS_RESET = 64;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD      = 2'd0,
        MODE_REASSIGN = 2'd1,
        MODE_ACCUM    = 2'd2,
        MODE_READ     = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_TOPIC = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_ADD_WR,
        S_RE_CMP,
        S_RE_DEC,
        S_RE_INC,
        S_ACC_RUN,
        S_ACC_TAIL,
        S_SUM_RUN,
        S_SUM_TAIL,
        S_DV_RD,
        S_DV_LD,
        S_DV_STEP,
        S_DV_OUT,
        S_REPLY
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic chk_latch;
        logic idx_clr;
        logic idx_inc;
        logic clr_write;
        logic st_write_add;
        logic st_write_re;
        logic st_rd;
        logic cnt_rd_topic;
        logic cnt_rd_old;
        logic cnt_wr_inc;
        logic cnt_wr_dec;
        logic acc_rd;
        logic acc_wr;
        logic sum_clr;
        logic sum_add;
        logic div_load;
        logic div_step;
        logic out_status;
        logic out_dist;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_status chk;
        t_mode   mode;
        logic    same;
        logic    idx_zero;
        logic    idx_last;
        logic    idx_max;
        logic    div_done;
        logic    out_free;
    } t_dp_stat;

endpackage

// File: hw/rtl/doc_topic_count_keeper_core.sv
`timescale 1ns / 1ps
// top level: configuration register, controller and datapath
// Usage: input items (mode, token index, topic) arrive on a valid/ready
// channel; results (topic index, fraction, status, last) leave on another.
// Add and reassign give one status result, accumulate gives one, readout
// gives one result per active topic T, with last on the final one.
// Readout first sums the accumulators of the T active topics, then for each
// topic takes one read, one load, 17 divide steps of one quotient bit each
// and one output step. The bit-serial divider serves the topics in turn;
// one item is in work at a time.
// topics_in_use sits at APB address 0; the user must see that it is written only
// while idle; the block does not enforce it. 0 acts as 1, values above 64 act as 64.
// After reset a clearing pass over all 64 entries zeroes the count and
// accumulator memories; no input is taken during it. The token store
// is not cleared. When the receiver stalls, the finished result waits in
// the output register and the block holds before loading the next one.
module doc_topic_count_keeper_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [dtck_pkg::MODE_W-1:0]      i_mode,
    input  logic [dtck_pkg::TOKEN_IDX_W-1:0] i_token_index,
    input  logic [dtck_pkg::TOPIC_W-1:0]     i_topic,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [dtck_pkg::TOPIC_W-1:0]     o_topic_index,
    output logic [dtck_pkg::FRAC_W-1:0]      o_fraction,
    output logic [dtck_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_last,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dtck_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dtck_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dtck_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import dtck_pkg::*;

    logic [CFG_W-1:0] r_topics_in_use;
    logic [CFG_W-1:0] t_act;
    logic             reg_sel;
    t_dp_cmd          cmd;
    t_dp_stat         stat;

    // register decode, register 0 at byte address 0
    assign reg_sel = (paddr[APB_ADDR_W-1] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(APB_DATA_W - CFG_W){1'b0}}, r_topics_in_use} : '0;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_topics_in_use <= CFG_W'(TOPICS_RESET);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_topics_in_use <= pwdata[CFG_W-1:0];
        end
    end

    // active topic count clamped to 1..MAX_TOPICS
    always_comb begin
        if (r_topics_in_use == '0) begin
            t_act = CFG_W'(1);
        end else if (r_topics_in_use > CFG_W'(MAX_TOPICS)) begin
            t_act = CFG_W'(MAX_TOPICS);
        end else begin
            t_act = r_topics_in_use;
        end
    end

    dtck_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dtck_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_t_act       (t_act),
        .i_mode        (i_mode),
        .i_token_index (i_token_index),
        .i_topic       (i_topic),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_topic_index (o_topic_index),
        .o_fraction    (o_fraction),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

// File: hw/rtl/dtck_ram.sv
`timescale 1ns / 1ps
// generic single-write single-read ram with registered read data
module dtck_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/dtck_ctrl.sv
`timescale 1ns / 1ps
// controller state machine sequencing every mode over the datapath
module dtck_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dtck_pkg::t_dp_stat i_stat,
    output dtck_pkg::t_dp_cmd  o_cmd
);
    import dtck_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.idx_max) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.chk != ST_OK) begin
                    n_state = S_REPLY;
                end else begin
                    case (i_stat.mode)
                        MODE_ADD:      n_state = S_ADD_WR;
                        MODE_REASSIGN: n_state = S_RE_CMP;
                        MODE_ACCUM:    n_state = S_ACC_RUN;
                        MODE_READ:     n_state = S_SUM_RUN;
                        default:       n_state = S_REPLY;
                    endcase
                end
            end
            S_ADD_WR: n_state = S_REPLY;
            S_RE_CMP: begin
                n_state = i_stat.same ? S_REPLY : S_RE_DEC;
            end
            S_RE_DEC: n_state = S_RE_INC;
            S_RE_INC: n_state = S_REPLY;
            S_ACC_RUN: begin
                if (i_stat.idx_last) n_state = S_ACC_TAIL;
            end
            S_ACC_TAIL: n_state = S_REPLY;
            S_SUM_RUN: begin
                if (i_stat.idx_last) n_state = S_SUM_TAIL;
            end
            S_SUM_TAIL: n_state = S_DV_RD;
            S_DV_RD:    n_state = S_DV_LD;
            S_DV_LD:    n_state = S_DV_STEP;
            S_DV_STEP: begin
                if (i_stat.div_done) n_state = S_DV_OUT;
            end
            S_DV_OUT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.idx_last ? S_IDLE : S_DV_RD;
                end
            end
            S_REPLY: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                o_cmd.idx_inc   = !i_stat.idx_max;
                o_cmd.idx_clr   = i_stat.idx_max;
            end
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
                o_cmd.idx_clr   = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.chk_latch = 1'b1;
                if (i_stat.chk == ST_OK) begin
                    case (i_stat.mode)
                        MODE_ADD: begin
                            o_cmd.st_write_add = 1'b1;
                            o_cmd.cnt_rd_topic = 1'b1;
                        end
                        MODE_REASSIGN: o_cmd.st_rd   = 1'b1;
                        MODE_READ:     o_cmd.sum_clr = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_ADD_WR: o_cmd.cnt_wr_inc = 1'b1;
            S_RE_CMP: begin
                o_cmd.st_write_re = !i_stat.same;
                o_cmd.cnt_rd_old  = !i_stat.same;
            end
            S_RE_DEC: begin
                o_cmd.cnt_wr_dec   = 1'b1;
                o_cmd.cnt_rd_topic = 1'b1;
            end
            S_RE_INC: o_cmd.cnt_wr_inc = 1'b1;
            S_ACC_RUN: begin
                o_cmd.acc_rd  = 1'b1;
                o_cmd.acc_wr  = !i_stat.idx_zero;
                o_cmd.idx_inc = !i_stat.idx_last;
            end
            S_ACC_TAIL: o_cmd.acc_wr = 1'b1;
            S_SUM_RUN: begin
                o_cmd.acc_rd  = 1'b1;
                o_cmd.sum_add = !i_stat.idx_zero;
                o_cmd.idx_inc = !i_stat.idx_last;
            end
            S_SUM_TAIL: begin
                o_cmd.sum_add = 1'b1;
                o_cmd.idx_clr = 1'b1;
            end
            S_DV_RD:   o_cmd.acc_rd   = 1'b1;
            S_DV_LD:   o_cmd.div_load = 1'b1;
            S_DV_STEP: o_cmd.div_step = 1'b1;
            S_DV_OUT: begin
                o_cmd.out_dist = i_stat.out_free;
                o_cmd.idx_inc  = i_stat.out_free && !i_stat.idx_last;
            end
            S_REPLY: o_cmd.out_status = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

// File: hw/rtl/dtck_dp.sv
`timescale 1ns / 1ps
// datapath: token and count stores, accumulate, sum, divider, result register
module dtck_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dtck_pkg::t_dp_cmd             i_cmd,
    output dtck_pkg::t_dp_stat            o_stat,
    input  logic [dtck_pkg::CFG_W-1:0]    i_t_act,
    input  logic [dtck_pkg::MODE_W-1:0]   i_mode,
    input  logic [dtck_pkg::TOKEN_IDX_W-1:0] i_token_index,
    input  logic [dtck_pkg::TOPIC_W-1:0]  i_topic,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dtck_pkg::TOPIC_W-1:0]  o_topic_index,
    output logic [dtck_pkg::FRAC_W-1:0]   o_fraction,
    output logic [dtck_pkg::STATUS_W-1:0] o_status,
    output logic                          o_last
);
    import dtck_pkg::*;

    // latched item and control counters
    t_mode                  r_mode;
    logic [TOKEN_IDX_W-1:0] r_tok_idx;
    logic [TOPIC_W-1:0]     r_topic;
    t_status                r_res_status;
    logic [TOKEN_CNT_W-1:0] r_token_count;
    logic [TOPIC_W-1:0]     r_idx;
    logic [TOPIC_W-1:0]     r_idx_d;
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       r_rem;
    logic [FRAC_W-1:0]      r_q;
    logic [DIV_CNT_W-1:0]   r_div_bit;

    // result register
    logic                   r_out_valid;
    logic [TOPIC_W-1:0]     r_out_topic;
    logic [FRAC_W-1:0]      r_out_frac;
    t_status                r_out_status;
    logic                   r_out_last;

    // ram ports
    logic                   st_wr_en;
    logic [TOKEN_IDX_W-1:0] st_wr_addr;
    logic [TOPIC_W-1:0]     st_rd_data;
    logic                   cnt_wr_en;
    logic [TOPIC_W-1:0]     cnt_wr_addr;
    logic [COUNT_W-1:0]     cnt_wr_data;
    logic                   cnt_rd_en;
    logic [TOPIC_W-1:0]     cnt_rd_addr;
    logic [COUNT_W-1:0]     cnt_rd_data;
    logic                   acc_wr_en;
    logic [TOPIC_W-1:0]     acc_wr_addr;
    logic [ACCUM_BITS-1:0]  acc_wr_data;
    logic [ACCUM_BITS-1:0]  acc_rd_data;

    // derived values
    logic [CFG_W-1:0]       t_act_m1;
    logic [TOPIC_W-1:0]     t_last;
    logic [COUNT_W-1:0]     cnt_inc;
    logic [COUNT_W-1:0]     cnt_dec;
    logic [ACCUM_BITS:0]    acc_sum;
    logic [ACCUM_BITS-1:0]  acc_new;
    logic [SUM_W-1:0]       acc_ext;
    logic [SUM_W:0]         div_shift;
    logic [SUM_W:0]         div_diff;
    logic                   div_ge;
    logic                   out_free;
    t_status                chk;

    assign t_act_m1 = i_t_act - CFG_W'(1);
    assign t_last   = t_act_m1[TOPIC_W-1:0];
    assign out_free = !r_out_valid || i_out_ready;

    // item checks, topic first, then store full or index range
    always_comb begin
        chk = ST_OK;
        if ((r_mode == MODE_ADD || r_mode == MODE_REASSIGN)
            && ({1'b0, r_topic} >= i_t_act)) begin
            chk = ST_BAD_TOPIC;
        end else if (r_mode == MODE_ADD
                     && r_token_count >= TOKEN_CNT_W'(MAX_TOKENS)) begin
            chk = ST_FULL;
        end else if (r_mode == MODE_REASSIGN
                     && {1'b0, r_tok_idx} >= r_token_count) begin
            chk = ST_BAD_INDEX;
        end
    end

    // status back to the controller
    always_comb begin
        o_stat.chk      = chk;
        o_stat.mode     = r_mode;
        o_stat.same     = (st_rd_data == r_topic);
        o_stat.idx_zero = (r_idx == '0);
        o_stat.idx_last = (r_idx == t_last);
        o_stat.idx_max  = (r_idx == TOPIC_W'(MAX_TOPICS - 1));
        o_stat.div_done = (r_div_bit == DIV_CNT_W'(DIV_STEPS - 1));
        o_stat.out_free = out_free;
    end

    // saturating count updates
    assign cnt_inc = (cnt_rd_data == COUNT_W'(COUNT_MAX)) ? cnt_rd_data
                                                         : cnt_rd_data + COUNT_W'(1);
    assign cnt_dec = (cnt_rd_data == '0) ? cnt_rd_data : cnt_rd_data - COUNT_W'(1);

    // saturating accumulate
    assign acc_sum = {1'b0, acc_rd_data}
                   + {{(ACCUM_BITS + 1 - COUNT_W){1'b0}}, cnt_rd_data};
    assign acc_new = acc_sum[ACCUM_BITS] ? '1 : acc_sum[ACCUM_BITS-1:0];
    assign acc_ext = {{(SUM_W - ACCUM_BITS){1'b0}}, acc_rd_data};

    // restoring divide step, the first step takes the integer bit unshifted
    assign div_shift = (r_div_bit == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign div_ge    = (div_shift >= {1'b0, r_sum});
    assign div_diff  = div_shift - {1'b0, r_sum};

    // token store ports
    assign st_wr_en   = i_cmd.st_write_add || i_cmd.st_write_re;
    assign st_wr_addr = i_cmd.st_write_add ? r_token_count[TOKEN_IDX_W-1:0] : r_tok_idx;

    // topic count ports
    always_comb begin
        cnt_rd_en   = i_cmd.cnt_rd_topic || i_cmd.cnt_rd_old || i_cmd.acc_rd;
        cnt_rd_addr = r_idx;
        if (i_cmd.cnt_rd_topic) begin
            cnt_rd_addr = r_topic;
        end else if (i_cmd.cnt_rd_old) begin
            cnt_rd_addr = st_rd_data;
        end
        cnt_wr_en   = i_cmd.clr_write || i_cmd.cnt_wr_inc || i_cmd.cnt_wr_dec;
        cnt_wr_addr = r_idx;
        cnt_wr_data = '0;
        if (i_cmd.cnt_wr_inc) begin
            cnt_wr_addr = r_topic;
            cnt_wr_data = cnt_inc;
        end else if (i_cmd.cnt_wr_dec) begin
            cnt_wr_addr = st_rd_data;
            cnt_wr_data = cnt_dec;
        end
    end

    // accumulator ports
    assign acc_wr_en   = i_cmd.clr_write || i_cmd.acc_wr;
    assign acc_wr_addr = i_cmd.acc_wr ? r_idx_d : r_idx;
    assign acc_wr_data = i_cmd.acc_wr ? acc_new : '0;

    dtck_ram #(
        .WIDTH (TOPIC_W),
        .DEPTH (MAX_TOKENS)
    ) u_token_ram (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (r_topic),
        .i_rd_en   (i_cmd.st_rd),
        .i_rd_addr (r_tok_idx),
        .o_rd_data (st_rd_data)
    );

    dtck_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_TOPICS)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_wr_en),
        .i_wr_addr (cnt_wr_addr),
        .i_wr_data (cnt_wr_data),
        .i_rd_en   (cnt_rd_en),
        .i_rd_addr (cnt_rd_addr),
        .o_rd_data (cnt_rd_data)
    );

    dtck_ram #(
        .WIDTH (ACCUM_BITS),
        .DEPTH (MAX_TOPICS)
    ) u_accum_ram (
        .i_clk     (i_clk),
        .i_wr_en   (acc_wr_en),
        .i_wr_addr (acc_wr_addr),
        .i_wr_data (acc_wr_data),
        .i_rd_en   (i_cmd.acc_rd),
        .i_rd_addr (r_idx),
        .o_rd_data (acc_rd_data)
    );

    // control counters and valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_count <= '0;
            r_idx         <= '0;
            r_div_bit     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.st_write_add) begin
                r_token_count <= r_token_count + TOKEN_CNT_W'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + TOPIC_W'(1);
            end
            if (i_cmd.div_load) begin
                r_div_bit <= '0;
            end else if (i_cmd.div_step) begin
                r_div_bit <= r_div_bit + DIV_CNT_W'(1);
            end
            if (i_cmd.out_status || i_cmd.out_dist) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item, sum and divider registers
    always_ff @(posedge i_clk) begin
        r_idx_d <= r_idx;
        if (i_cmd.load_item) begin
            r_mode    <= t_mode'(i_mode);
            r_tok_idx <= i_token_index;
            r_topic   <= i_topic;
        end
        if (i_cmd.chk_latch) begin
            r_res_status <= chk;
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + acc_ext;
        end
        if (i_cmd.div_load) begin
            r_rem <= acc_ext;
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_diff[SUM_W-1:0] : div_shift[SUM_W-1:0];
            r_q   <= {r_q[FRAC_W-2:0], div_ge};
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_status) begin
            r_out_topic  <= '0;
            r_out_frac   <= '0;
            r_out_status <= r_res_status;
            r_out_last   <= 1'b1;
        end else if (i_cmd.out_dist) begin
            r_out_topic  <= r_idx;
            r_out_frac   <= (r_sum == '0) ? '0 : r_q;
            r_out_status <= ST_OK;
            r_out_last   <= (r_idx == t_last);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_topic_index = r_out_topic;
    assign o_fraction    = r_out_frac;
    assign o_status      = r_out_status;
    assign o_last        = r_out_last;

`ifndef SYNTH
    // token count never passes the store depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_token_count <= TOKEN_CNT_W'(MAX_TOKENS))
        else $error("token count beyond store depth");

    // an append only happens with room in the store
    a_add_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.st_write_add |-> (r_token_count < TOKEN_CNT_W'(MAX_TOKENS)))
        else $error("append into a full token store");

    // a result is never loaded over one still waiting
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_status || i_cmd.out_dist) |-> out_free)
        else $error("result register overwritten");

    // the divider never runs past its quotient width
    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_div_bit < DIV_CNT_W'(DIV_STEPS)))
        else $error("divider stepped too often");
`endif

endmodule

// File: verif/tb_doc_topic_count_keeper_core.sv
`timescale 1ns / 1ps
// self-checking testbench of the document topic-count keeper core
module tb_doc_topic_count_keeper_core;
    import dtck_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 200;
    localparam logic [APB_ADDR_W-1:0] ADDR_TOPICS_IN_USE = '0;
    localparam longint unsigned ACCUM_FULL = (64'd1 << ACCUM_BITS) - 1;

    // one expected result
    typedef struct {
        logic [TOPIC_W-1:0] topic_index;
        logic [FRAC_W-1:0]  fraction;
        t_status            status;
        logic               last;
    } t_reply;

    // clock
    logic i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [MODE_W-1:0]       i_mode;
    logic [TOKEN_IDX_W-1:0]  i_token_index;
    logic [TOPIC_W-1:0]      i_topic;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [TOPIC_W-1:0]      o_topic_index;
    logic [FRAC_W-1:0]       o_fraction;
    logic [STATUS_W-1:0]     o_status;
    logic                    o_last;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    doc_topic_count_keeper_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_token_index (i_token_index),
        .i_topic       (i_topic),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_topic_index (o_topic_index),
        .o_fraction    (o_fraction),
        .o_status      (o_status),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // bookkeeping mirror of the document
    logic [TOPIC_W-1:0]    tok_topic [MAX_TOKENS];
    int                    tok_total;
    int                    topic_tally [MAX_TOPICS];
    logic [ACCUM_BITS-1:0] topic_accum [MAX_TOPICS];
    logic [CFG_W-1:0]      topics_cfg;
    t_reply                queued_replies [$];

    int mismatches     = 0;
    int replies_seen   = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    function automatic int active_topics();
        if (topics_cfg == 0) return 1;
        if (topics_cfg > MAX_TOPICS) return MAX_TOPICS;
        return topics_cfg;
    endfunction

    // update the mirror for one accepted item and queue its results
    task automatic tally_item(input t_mode mode, input logic [TOKEN_IDX_W-1:0] index,
                              input logic [TOPIC_W-1:0] topic);
        int              span;
        int              old;
        longint unsigned total;
        longint unsigned grown;
        longint unsigned scaled;
        t_reply          r;
        span          = active_topics();
        r.topic_index = '0;
        r.fraction    = '0;
        r.status      = ST_OK;
        r.last        = 1'b1;
        case (mode)
            MODE_ADD: begin
                if (topic >= span) begin
                    r.status = ST_BAD_TOPIC;
                end else if (tok_total >= MAX_TOKENS) begin
                    r.status = ST_FULL;
                end else begin
                    tok_topic[tok_total] = topic;
                    tok_total++;
                    if (topic_tally[topic] < COUNT_MAX) topic_tally[topic]++;
                end
                queued_replies.insert(queued_replies.size(), r);
            end
            MODE_REASSIGN: begin
                // topic check comes ahead of the index check
                if (topic >= span) begin
                    r.status = ST_BAD_TOPIC;
                end else if (index >= tok_total) begin
                    r.status = ST_BAD_INDEX;
                end else if (tok_topic[index] != topic) begin
                    old              = tok_topic[index];
                    tok_topic[index] = topic;
                    if (topic_tally[old] > 0) topic_tally[old]--;
                    if (topic_tally[topic] < COUNT_MAX) topic_tally[topic]++;
                end
                queued_replies.insert(queued_replies.size(), r);
            end
            MODE_ACCUM: begin
                for (int i = 0; i < span; i++) begin
                    grown = topic_accum[i];
                    grown = grown + topic_tally[i];
                    if (grown > ACCUM_FULL) topic_accum[i] = '1;
                    else topic_accum[i] = grown[ACCUM_BITS-1:0];
                end
                queued_replies.insert(queued_replies.size(), r);
            end
            MODE_READ: begin
                total = 0;
                for (int i = 0; i < span; i++) total += topic_accum[i];
                for (int i = 0; i < span; i++) begin
                    scaled        = topic_accum[i];
                    r.topic_index = i[TOPIC_W-1:0];
                    r.fraction    = (total == 0) ? '0 : FRAC_W'((scaled << 16) / total);
                    r.last        = (i == span - 1);
                    queued_replies.insert(queued_replies.size(), r);
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s wrong on result %0d: got %0d, expected %0d",
                 $time, what, replies_seen, got, want);
        mismatches++;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // one item over the input channel, entered and left at a falling edge
    task automatic send_item(input t_mode mode, input logic [TOKEN_IDX_W-1:0] index,
                             input logic [TOPIC_W-1:0] topic);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_token_index <= index;
        i_topic       <= topic;
        do @(posedge i_clk); while (!o_in_ready);
        tally_item(mode, index, topic);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (queued_replies.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // register write, only once the block has gone quiet
    task automatic write_topics(input logic [APB_DATA_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TOPICS_IN_USE;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        topics_cfg = value[CFG_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly well-formed traffic: topics in range, indexes of stored tokens
    task automatic run_random_phase(input int n_items, input int send_pct, input int recv_pct);
        int                     pick;
        int                     span;
        t_mode                  mode;
        logic [TOKEN_IDX_W-1:0] index;
        logic [TOPIC_W-1:0]     topic;
        set_idling(send_pct, recv_pct);
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 35) mode = MODE_ADD;
            else if (pick < 70) mode = MODE_REASSIGN;
            else if (pick < 92) mode = MODE_ACCUM;
            else mode = MODE_READ;
            span = active_topics();
            if ($urandom_range(99) < 85) topic = TOPIC_W'($urandom_range(span - 1));
            else topic = TOPIC_W'($urandom_range(MAX_TOPICS - 1));
            if (tok_total > 0 && $urandom_range(99) < 80)
                index = TOKEN_IDX_W'($urandom_range(tok_total - 1));
            else index = TOKEN_IDX_W'($urandom_range(MAX_TOKENS - 1));
            send_item(mode, index, topic);
        end
    endtask

    task automatic test_zero_total();
        set_idling(0, 0);
        send_item(MODE_READ, '0, '0);
    endtask

    task automatic test_each_mode();
        write_topics(4);
        set_idling(0, 0);
        send_item(MODE_ADD, '0, TOPIC_W'(0));
        send_item(MODE_ADD, '0, TOPIC_W'(3));
        send_item(MODE_ADD, '0, TOPIC_W'(4));
        send_item(MODE_ADD, '0, TOPIC_W'(MAX_TOPICS - 1));
        send_item(MODE_REASSIGN, TOKEN_IDX_W'(0), TOPIC_W'(3));
        // same topic again leaves the counts alone
        send_item(MODE_REASSIGN, TOKEN_IDX_W'(1), TOPIC_W'(3));
        send_item(MODE_REASSIGN, TOKEN_IDX_W'(2), TOPIC_W'(1));
        send_item(MODE_REASSIGN, TOKEN_IDX_W'(MAX_TOKENS - 1), TOPIC_W'(MAX_TOPICS - 1));
        send_item(MODE_REASSIGN, TOKEN_IDX_W'(MAX_TOKENS - 1), TOPIC_W'(1));
        send_item(MODE_READ, '0, '0);
        send_item(MODE_ACCUM, '0, '0);
        send_item(MODE_READ, '0, '0);
        send_item(MODE_ADD, '0, TOPIC_W'(2));
        send_item(MODE_ACCUM, '0, '0);
        send_item(MODE_READ, '0, '0);
    endtask

    task automatic test_topic_limits();
        // zero acts as one topic, a single topic reads back as the full fraction
        write_topics(0);
        send_item(MODE_ADD, '0, TOPIC_W'(0));
        send_item(MODE_ADD, '0, TOPIC_W'(1));
        send_item(MODE_ACCUM, '0, '0);
        send_item(MODE_READ, '0, '0);
        // above the topic count clamps to the maximum
        write_topics(127);
        send_item(MODE_ADD, '0, TOPIC_W'(MAX_TOPICS - 1));
        send_item(MODE_ACCUM, '0, '0);
        send_item(MODE_READ, '0, '0);
        write_topics(MAX_TOPICS + 1);
        send_item(MODE_ADD, '0, TOPIC_W'(MAX_TOPICS - 1));
    endtask

    task automatic test_topic_shrink();
        logic [TOKEN_IDX_W-1:0] newest;
        write_topics(4);
        send_item(MODE_ADD, '0, TOPIC_W'(3));
        newest = TOKEN_IDX_W'(tok_total - 1);
        // counts above a lowered topic count stay and can still be moved away
        write_topics(2);
        send_item(MODE_REASSIGN, newest, TOPIC_W'(0));
        send_item(MODE_REASSIGN, newest, TOPIC_W'(3));
        send_item(MODE_ADD, '0, TOPIC_W'(2));
        send_item(MODE_ACCUM, '0, '0);
        send_item(MODE_READ, '0, '0);
        write_topics(4);
        send_item(MODE_READ, '0, '0);
    endtask

    task automatic test_random_traffic();
        write_topics(TOPICS_RESET);
        run_random_phase(46, 0, 0);
        write_topics(1);
        run_random_phase(46, 48, 0);
        write_topics($urandom_range(2, MAX_TOPICS - 1));
        run_random_phase(46, 0, 48);
        // junk above the register field, zero below it
        write_topics($urandom() & ~32'h7F);
        run_random_phase(46, 11, 11);
        write_topics(100);
        run_random_phase(46, 48, 0);
        write_topics($urandom_range(1, MAX_TOPICS));
        run_random_phase(46, 11, 11);
    endtask

    task automatic test_store_bounds();
        logic [TOPIC_W-1:0]     topic;
        logic [TOKEN_IDX_W-1:0] newest;
        write_topics(MAX_TOPICS);
        set_idling(11, 11);
        send_item(MODE_ADD, '0, TOPIC_W'(5));
        send_item(MODE_ADD, TOKEN_IDX_W'(MAX_TOKENS - 1), TOPIC_W'(MAX_TOPICS - 1));
        newest = TOKEN_IDX_W'(tok_total - 1);
        topic  = TOPIC_W'($urandom_range(MAX_TOPICS - 1));
        // highest index, beyond the stored tokens
        send_item(MODE_REASSIGN, TOKEN_IDX_W'(MAX_TOKENS - 1), topic);
        // newest token moved to the topic it already holds
        send_item(MODE_REASSIGN, newest, tok_topic[newest]);
        write_topics(8);
        run_random_phase(20, 0, 48);
    endtask

    // receiver readiness
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare every result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (queued_replies.size() == 0) begin
                report_mismatch("unexpected result, topic_index", o_topic_index, 0);
            end else begin
                want = queued_replies.pop_front();
                if (o_topic_index !== want.topic_index)
                    report_mismatch("topic_index", o_topic_index, want.topic_index);
                if (o_fraction !== want.fraction)
                    report_mismatch("fraction", o_fraction, want.fraction);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
            end
            replies_seen++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_ADD;
        i_token_index = '0;
        i_topic       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tok_total     = 0;
        topic_tally   = '{default: 0};
        topic_accum   = '{default: '0};
        topics_cfg    = CFG_W'(TOPICS_RESET);
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_total();
        test_each_mode();
        test_topic_limits();
        test_topic_shrink();
        test_random_traffic();
        test_store_bounds();

        // let any surplus result show up
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/dtck_pkg.sv
hw/rtl/dtck_ram.sv
hw/rtl/dtck_ctrl.sv
hw/rtl/dtck_dp.sv
hw/rtl/doc_topic_count_keeper_core.sv
verif/tb_doc_topic_count_keeper_core.sv
